### rtl/finder_pattern_orderer_assert.svh
// Assertion macros shared by the finder pattern orderer RTL.
`ifndef FINDER_PATTERN_ORDERER_ASSERT_SVH
`define FINDER_PATTERN_ORDERER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FPO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpo assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define FPO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpo assertion failed");

`endif

### rtl/fpo_pkg.sv
// Shared types and constants of the finder pattern orderer.
`timescale 1ns / 1ps
package fpo_pkg;

  localparam int COORD_BITS = 16;
  localparam int SQ_BITS    = 2 * COORD_BITS + 1;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS + 2;
  localparam int NUM_STAGES = 7;

  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic [SQ_BITS-1:0]          sq_t;
  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic [1:0]                  idx_t;

  localparam idx_t IDX_FIRST  = 2'd0;
  localparam idx_t IDX_SECOND = 2'd1;
  localparam idx_t IDX_THIRD  = 2'd2;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Stage enables of a distance lane.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_en_t;

  // Stage enables of the merge stage.
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } merge_en_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
    idx_t   src_a;
    idx_t   src_b;
    idx_t   src_c;
  } result_t;

endpackage

### rtl/fpo_points_if.sv
// Valid/ready channels for input point triples and ordered corner results.
`timescale 1ns / 1ps
interface fpo_points_if;
  import fpo_pkg::*;
  logic   valid;
  logic   ready;
  coord_t first_x;
  coord_t first_y;
  coord_t second_x;
  coord_t second_y;
  coord_t third_x;
  coord_t third_y;

  modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                output ready);
endinterface

interface fpo_corners_if;
  import fpo_pkg::*;
  logic   valid;
  logic   ready;
  coord_t corner_a_x;
  coord_t corner_a_y;
  coord_t corner_b_x;
  coord_t corner_b_y;
  coord_t corner_c_x;
  coord_t corner_c_y;
  idx_t   source_of_a;
  idx_t   source_of_b;
  idx_t   source_of_c;

  modport source (output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, source_of_a, source_of_b, source_of_c,
                  input ready);
  modport sink (input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                corner_c_x, corner_c_y, source_of_a, source_of_b, source_of_c,
                output ready);
endinterface

### rtl/fpo_dist_lane.sv
// One distance lane: exact squared distance between two points, three stages.
`timescale 1ns / 1ps
module fpo_dist_lane (
  input  logic             clk,
  input  fpo_pkg::lane_en_t en,
  input  fpo_pkg::point_t   p,
  input  fpo_pkg::point_t   q,
  output fpo_pkg::sq_t      sq_dist
);
  import fpo_pkg::*;

  localparam int SQR_BITS = 2 * COORD_BITS;

  coord_t              dx;
  coord_t              dy;
  logic [SQR_BITS-1:0] sx;
  logic [SQR_BITS-1:0] sy;
  logic [SQR_BITS-1:0] dx_w;
  logic [SQR_BITS-1:0] dy_w;

  assign dx_w = {{COORD_BITS{1'b0}}, dx};
  assign dy_w = {{COORD_BITS{1'b0}}, dy};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dx <= (p.x >= q.x) ? (p.x - q.x) : (q.x - p.x);
      dy <= (p.y >= q.y) ? (p.y - q.y) : (q.y - p.y);
    end
    if (en.s2) begin
      sx <= dx_w * dx_w;
      sy <= dy_w * dy_w;
    end
    if (en.s3) begin
      sq_dist <= {1'b0, sx} + {1'b0, sy};
    end
  end

endmodule

### rtl/fpo_merge.sv
// Merge stage: picks corner B, forms the cross product, orders A and C.
`timescale 1ns / 1ps
module fpo_merge (
  input  logic               clk,
  input  fpo_pkg::merge_en_t en,
  input  fpo_pkg::point_t    pts [3],
  input  fpo_pkg::sq_t       d01,
  input  fpo_pkg::sq_t       d12,
  input  fpo_pkg::sq_t       d02,
  output fpo_pkg::result_t   result
);
  import fpo_pkg::*;

  // stage 4: selected points
  point_t pa4, pb4, pc4;
  idx_t   ia4, ib4, ic4;
  // stage 5: differences around B
  point_t pa5, pb5, pc5;
  idx_t   ia5, ib5, ic5;
  diff_t  cxb, ayb, cyb, axb;
  // stage 6: products
  point_t pa6, pb6, pc6;
  idx_t   ia6, ib6, ic6;
  prod_t  left, right;

  logic   b_first;
  logic   b_second;

  assign b_first  = (d12 >= d01) && (d12 >= d02);
  assign b_second = (d02 >= d12) && (d02 >= d01);

  function automatic diff_t sdiff(coord_t u, coord_t v);
    return diff_t'({1'b0, u}) - diff_t'({1'b0, v});
  endfunction

  always_ff @(posedge clk) begin
    if (en.s4) begin
      if (b_first) begin
        pb4 <= pts[0]; pa4 <= pts[1]; pc4 <= pts[2];
        ib4 <= IDX_FIRST; ia4 <= IDX_SECOND; ic4 <= IDX_THIRD;
      end else if (b_second) begin
        pb4 <= pts[1]; pa4 <= pts[0]; pc4 <= pts[2];
        ib4 <= IDX_SECOND; ia4 <= IDX_FIRST; ic4 <= IDX_THIRD;
      end else begin
        pb4 <= pts[2]; pa4 <= pts[0]; pc4 <= pts[1];
        ib4 <= IDX_THIRD; ia4 <= IDX_FIRST; ic4 <= IDX_SECOND;
      end
    end
    if (en.s5) begin
      pa5 <= pa4; pb5 <= pb4; pc5 <= pc4;
      ia5 <= ia4; ib5 <= ib4; ic5 <= ic4;
      cxb <= sdiff(pc4.x, pb4.x);
      ayb <= sdiff(pa4.y, pb4.y);
      cyb <= sdiff(pc4.y, pb4.y);
      axb <= sdiff(pa4.x, pb4.x);
    end
    if (en.s6) begin
      pa6 <= pa5; pb6 <= pb5; pc6 <= pc5;
      ia6 <= ia5; ib6 <= ib5; ic6 <= ic5;
      left  <= prod_t'(cxb) * prod_t'(ayb);
      right <= prod_t'(cyb) * prod_t'(axb);
    end
    if (en.s7) begin
      // negative z = left - right swaps A and C
      if (left < right) begin
        result.a <= pc6; result.c <= pa6;
        result.src_a <= ic6; result.src_c <= ia6;
      end else begin
        result.a <= pa6; result.c <= pc6;
        result.src_a <= ia6; result.src_c <= ic6;
      end
      result.b     <= pb6;
      result.src_b <= ib6;
    end
  end

endmodule

### rtl/finder_pattern_orderer.sv
// Top level of the finder pattern orderer: lanes, merge stage and pipeline control.
`timescale 1ns / 1ps
// Orders three QR finder-pattern centers (unsigned Q12.4 coordinates) into
// corners A, B, C. Corner B is the point opposite the longest side, found by
// comparing exact squared distances; ties favor B = first, then B = second.
// A and C are swapped only when the z component of BC x BA is strictly
// negative. Each corner also reports the input index (0..2) it came from.
// Rate: one item per clock, sustained while corners.ready is high. The depth
// comes from three distance-lane stages (difference, square, sum) and four
// merge stages (select B, differences, cross-product multiplies, compare and
// swap). Each stage has its own valid bit and loads whenever it is empty or
// its successor moves, so a stall on corners backs up stage by stage and
// points.ready drops only once all seven stages hold an item. The final stage
// is the output register.
// Reset clears the valid bits only; no clearing pass is needed.
`include "finder_pattern_orderer_assert.svh"
module finder_pattern_orderer (
  input logic    clk,
  input logic    rst,
  fpo_points_if.sink    points,
  fpo_corners_if.source corners
);
  import fpo_pkg::*;

  logic [NUM_STAGES-1:0] v;    // stage valid bits
  logic [NUM_STAGES-1:0] en;   // stage load enables

  point_t   pts_in [3];
  point_t   pts_s1 [3];
  point_t   pts_s2 [3];
  point_t   pts_s3 [3];
  sq_t      d01, d12, d02;
  lane_en_t  lane_en;
  merge_en_t merge_en;
  result_t   result;

  // Stall chain: a stage loads when empty or when the next one loads.
  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || corners.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= points.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign points.ready = en[0];

  assign pts_in[0] = '{x: points.first_x,  y: points.first_y};
  assign pts_in[1] = '{x: points.second_x, y: points.second_y};
  assign pts_in[2] = '{x: points.third_x,  y: points.third_y};

  // Points ride alongside the distance lanes until the merge stage.
  always_ff @(posedge clk) begin
    if (en[0]) pts_s1 <= pts_in;
    if (en[1]) pts_s2 <= pts_s1;
    if (en[2]) pts_s3 <= pts_s2;
  end

  assign lane_en  = '{s1: en[0], s2: en[1], s3: en[2]};
  assign merge_en = '{s4: en[3], s5: en[4], s6: en[5], s7: en[6]};

  // Three lanes, one per side of the triangle.
  fpo_dist_lane u_lane01 (.clk(clk), .en(lane_en), .p(pts_in[0]), .q(pts_in[1]), .sq_dist(d01));
  fpo_dist_lane u_lane12 (.clk(clk), .en(lane_en), .p(pts_in[1]), .q(pts_in[2]), .sq_dist(d12));
  fpo_dist_lane u_lane02 (.clk(clk), .en(lane_en), .p(pts_in[0]), .q(pts_in[2]), .sq_dist(d02));

  fpo_merge u_merge (
    .clk    (clk),
    .en     (merge_en),
    .pts    (pts_s3),
    .d01    (d01),
    .d12    (d12),
    .d02    (d02),
    .result (result)
  );

  assign corners.valid       = v[NUM_STAGES-1];
  assign corners.corner_a_x  = result.a.x;
  assign corners.corner_a_y  = result.a.y;
  assign corners.corner_b_x  = result.b.x;
  assign corners.corner_b_y  = result.b.y;
  assign corners.corner_c_x  = result.c.x;
  assign corners.corner_c_y  = result.c.y;
  assign corners.source_of_a = result.src_a;
  assign corners.source_of_b = result.src_b;
  assign corners.source_of_c = result.src_c;

  // The three sources form a permutation of the input indexes.
  `FPO_ASSERT_IMP(a_src_perm, corners.valid,
    (corners.source_of_a != corners.source_of_b) &&
    (corners.source_of_b != corners.source_of_c) &&
    (corners.source_of_a != corners.source_of_c) &&
    (corners.source_of_a != 2'd3) && (corners.source_of_b != 2'd3) &&
    (corners.source_of_c != 2'd3))
  // Input backs off only when every stage is full and the output stalls.
  `FPO_ASSERT_IMP(a_full_stall, !points.ready, (&v) && !corners.ready)
  // An accepted item occupies the first stage next cycle.
  `FPO_ASSERT_NEXT(a_accept_fill, points.valid && points.ready, v[0])

endmodule

### dv/tb_top.sv
// Self-checking testbench of the finder pattern orderer: directed table plus random triples.
`timescale 1ns / 1ps
module tb_top;
  import fpo_pkg::*;

  // Run length and safety net. The slowest correct run is roughly 1400 items,
  // each slowed by sender gaps and receiver stalls, so the limit is generous.
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 120;   // well past the seven pipeline stages
  localparam int NUM_DIRECTED = 16;

  typedef struct packed {
    point_t p0;
    point_t p1;
    point_t p2;
  } trio_t;

  // One row of the directed table. When typed is set, want holds the expected
  // corners written out by hand; otherwise the predictor supplies them.
  typedef struct packed {
    trio_t   pts;
    logic    typed;
    result_t want;
  } row_t;

  logic clk;
  logic rst;

  fpo_points_if  points();
  fpo_corners_if corners();

  finder_pattern_orderer i_dut (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .corners (corners)
  );

  result_t expected_corners[$];   // ordered corners still owed by the block
  int      errors = 0;
  int      cycle_count = 0;
  int      hold_reqs = 0;         // sender's requests for one long receiver hold-off

  // Directed table: extremes, both orientations, every tie in the choice of B,
  // collinear and coincident points.
  row_t directed_rows [NUM_DIRECTED] = '{
    // all points coincident at the origin: every side ties, B is the first point
    '{'{'{16'h0000, 16'h0000}, '{16'h0000, 16'h0000}, '{16'h0000, 16'h0000}}, 1'b1,
      '{'{16'h0000, 16'h0000}, '{16'h0000, 16'h0000}, '{16'h0000, 16'h0000},
        IDX_SECOND, IDX_FIRST, IDX_THIRD}},
    // all points coincident at the top corner of the coordinate range
    '{'{'{16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'hFFFF}}, 1'b1,
      '{'{16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'hFFFF},
        IDX_SECOND, IDX_FIRST, IDX_THIRD}},
    // full-range right angle at the first point, negative cross: A and C swap
    '{'{'{16'h0000, 16'h0000}, '{16'hFFFF, 16'h0000}, '{16'h0000, 16'hFFFF}}, 1'b1,
      '{'{16'h0000, 16'hFFFF}, '{16'h0000, 16'h0000}, '{16'hFFFF, 16'h0000},
        IDX_THIRD, IDX_FIRST, IDX_SECOND}},
    // same triangle mirrored, positive cross: order kept
    '{'{'{16'h0000, 16'h0000}, '{16'h0000, 16'hFFFF}, '{16'hFFFF, 16'h0000}}, 1'b1,
      '{'{16'h0000, 16'hFFFF}, '{16'h0000, 16'h0000}, '{16'hFFFF, 16'h0000},
        IDX_SECOND, IDX_FIRST, IDX_THIRD}},
    // typical finder layout, corner at the second point
    '{'{'{16'h3200, 16'h0A00}, '{16'h0A00, 16'h0A00}, '{16'h0A00, 16'h3200}}, 1'b0, '0},
    // corner at the first point, rotated
    '{'{'{16'h1E00, 16'h5000}, '{16'h6400, 16'h2800}, '{16'h1400, 16'h1400}}, 1'b0, '0},
    // two longest sides tie: side 1-2 against side 0-2, B = first wins
    '{'{'{16'h0000, 16'h0000}, '{16'h000A, 16'h0000}, '{16'h0005, 16'h0064}}, 1'b0, '0},
    // two longest sides tie: side 0-2 against side 0-1, B = second wins
    '{'{'{16'h0005, 16'h0064}, '{16'h0000, 16'h0000}, '{16'h000A, 16'h0000}}, 1'b0, '0},
    // two longest sides tie: side 1-2 against side 0-1
    '{'{'{16'h0000, 16'h0000}, '{16'h0005, 16'h0064}, '{16'h000A, 16'h0000}}, 1'b0, '0},
    // collinear, longest side 0-2, zero cross product
    '{'{'{16'h0000, 16'h0000}, '{16'h000A, 16'h000A}, '{16'h0014, 16'h0014}}, 1'b0, '0},
    // collinear, longest side 0-1, corner at the third point
    '{'{'{16'h0000, 16'h0000}, '{16'h0028, 16'h0000}, '{16'h0014, 16'h0000}}, 1'b0, '0},
    // first two points coincident
    '{'{'{16'h012C, 16'h012C}, '{16'h012C, 16'h012C}, '{16'h0000, 16'h0000}}, 1'b0, '0},
    // large coordinates near the range edges
    '{'{'{16'hFFFF, 16'h0000}, '{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF}}, 1'b0, '0},
    // alternating bit patterns
    '{'{'{16'hAAAA, 16'h5555}, '{16'h5555, 16'hAAAA}, '{16'hFFFF, 16'h0000}}, 1'b0, '0},
    // tiny triangle around the middle of the range
    '{'{'{16'h8000, 16'h8000}, '{16'h7FFF, 16'h7FFF}, '{16'h8001, 16'h7FFF}}, 1'b0, '0},
    // opposite orientation of the typical layout
    '{'{'{16'h0A00, 16'h3200}, '{16'h0A00, 16'h0A00}, '{16'h3200, 16'h0A00}}, 1'b0, '0}
  };

  // Exact squared distance between two points, wide enough for any coordinate.
  function automatic longint sq_span(point_t p, point_t q);
    longint dx;
    longint dy;
    dx = longint'({48'd0, p.x}) - longint'({48'd0, q.x});
    dy = longint'({48'd0, p.y}) - longint'({48'd0, q.y});
    return dx * dx + dy * dy;
  endfunction

  // Predictor: B sits opposite the longest side (ties go to the first, then
  // the second point); A and C swap only on a strictly negative BC x BA.
  function automatic result_t order_corners(trio_t t);
    point_t  pt [3];
    longint  d01;
    longint  d12;
    longint  d02;
    longint  lhs;
    longint  rhs;
    idx_t    ia;
    idx_t    ib;
    idx_t    ic;
    idx_t    tmp;
    result_t r;
    pt[0] = t.p0;
    pt[1] = t.p1;
    pt[2] = t.p2;
    d01 = sq_span(pt[0], pt[1]);
    d12 = sq_span(pt[1], pt[2]);
    d02 = sq_span(pt[0], pt[2]);
    if (d12 >= d01 && d12 >= d02) begin
      ib = IDX_FIRST;  ia = IDX_SECOND; ic = IDX_THIRD;
    end else if (d02 >= d12 && d02 >= d01) begin
      ib = IDX_SECOND; ia = IDX_FIRST;  ic = IDX_THIRD;
    end else begin
      ib = IDX_THIRD;  ia = IDX_FIRST;  ic = IDX_SECOND;
    end
    // z = (cx-bx)*(ay-by) - (cy-by)*(ax-bx); exact in 64 bits
    lhs = (longint'({48'd0, pt[ic].x}) - longint'({48'd0, pt[ib].x})) *
          (longint'({48'd0, pt[ia].y}) - longint'({48'd0, pt[ib].y}));
    rhs = (longint'({48'd0, pt[ic].y}) - longint'({48'd0, pt[ib].y})) *
          (longint'({48'd0, pt[ia].x}) - longint'({48'd0, pt[ib].x}));
    if (lhs < rhs) begin
      tmp = ia; ia = ic; ic = tmp;
    end
    r.a     = pt[ia];
    r.b     = pt[ib];
    r.c     = pt[ic];
    r.src_a = ia;
    r.src_b = ib;
    r.src_c = ic;
    return r;
  endfunction

  // Random triple. Most are shaped like real finder layouts or sit on the tie
  // and collinear boundaries; the rest are uniform noise or tight clusters.
  function automatic trio_t random_trio();
    point_t p [3];
    point_t tmp;
    trio_t  t;
    int     kind;
    int     bx;
    int     by;
    int     u;
    int     v;
    int     k;
    int     j;
    kind = $urandom_range(0, 99);
    bx   = $urandom_range(0, 65535);
    by   = $urandom_range(0, 65535);
    u    = int'($urandom_range(0, 32000)) - 16000;
    v    = int'($urandom_range(0, 32000)) - 16000;
    if (kind < 35) begin
      for (j = 0; j < 3; j++) begin
        p[j].x = coord_t'($urandom_range(0, 65535));
        p[j].y = coord_t'($urandom_range(0, 65535));
      end
    end else if (kind < 65) begin
      // right angle with near-equal legs, a little jitter on the far corners
      p[1].x = coord_t'(bx);
      p[1].y = coord_t'(by);
      p[0].x = coord_t'(bx + u + int'($urandom_range(0, 3)));
      p[0].y = coord_t'(by + v + int'($urandom_range(0, 3)));
      p[2].x = coord_t'(bx - v + int'($urandom_range(0, 3)));
      p[2].y = coord_t'(by + u + int'($urandom_range(0, 3)));
    end else if (kind < 80) begin
      // isosceles: two sides from the apex are exactly equal
      p[0].x = coord_t'(bx);
      p[0].y = coord_t'(by + v);
      p[1].x = coord_t'(bx + u);
      p[1].y = coord_t'(by);
      p[2].x = coord_t'(bx - u);
      p[2].y = coord_t'(by);
    end else if (kind < 88) begin
      // collinear: zero cross product
      u = int'($urandom_range(0, 100)) - 50;
      v = int'($urandom_range(0, 100)) - 50;
      for (j = 0; j < 3; j++) begin
        k = int'($urandom_range(0, 200)) - 100;
        p[j].x = coord_t'(bx + k * u);
        p[j].y = coord_t'(by + k * v);
      end
    end else begin
      // tight cluster: coincident points and ties are common
      for (j = 0; j < 3; j++) begin
        p[j].x = coord_t'(bx + int'($urandom_range(0, 3)));
        p[j].y = coord_t'(by + int'($urandom_range(0, 3)));
      end
    end
    // random order of the three points
    j = $urandom_range(0, 2);
    tmp = p[0]; p[0] = p[j]; p[j] = tmp;
    j = $urandom_range(1, 2);
    tmp = p[1]; p[1] = p[j]; p[j] = tmp;
    t.p0 = p[0];
    t.p1 = p[1];
    t.p2 = p[2];
    return t;
  endfunction

  // Idle length: mostly none, sometimes a short gap, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one triple after an optional gap; returns at the edge that accepts it.
  task automatic offer_trio(trio_t t, int gap);
    if (gap > 0) begin
      points.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points.valid    <= 1'b1;
    points.first_x  <= t.p0.x;
    points.first_y  <= t.p0.y;
    points.second_x <= t.p1.x;
    points.second_y <= t.p1.y;
    points.third_x  <= t.p2.x;
    points.third_y  <= t.p2.y;
    do @(posedge clk); while (!points.ready);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Clock: 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reset held at the start only, never again.
  initial begin
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, stretches of steady ready, and on request one long
  // hold-off so the pipeline fills and points.ready drops.
  initial begin : corner_sink
    int r;
    int open_left;
    int holds_done;
    open_left  = 0;
    holds_done = 0;
    corners.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        corners.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (open_left > 0) begin
        corners.ready <= 1'b1;
        open_left--;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          open_left = $urandom_range(30, 80);
          corners.ready <= 1'b1;
          @(posedge clk);
        end else if (r < 55) begin
          corners.ready <= 1'b1;
          @(posedge clk);
        end else if (r < 92) begin
          corners.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          corners.ready <= 1'b0;
          repeat ($urandom_range(6, 40)) @(posedge clk);
        end
      end
    end
  end

  // Result checker: every accepted item is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && corners.valid && corners.ready) begin
      if (expected_corners.size() == 0) begin
        $error("corner item with no expectation pending");
        errors++;
      end else begin
        want = expected_corners.pop_front();
        check_field("corner_a_x",  want.a.x,  corners.corner_a_x);
        check_field("corner_a_y",  want.a.y,  corners.corner_a_y);
        check_field("corner_b_x",  want.b.x,  corners.corner_b_x);
        check_field("corner_b_y",  want.b.y,  corners.corner_b_y);
        check_field("corner_c_x",  want.c.x,  corners.corner_c_x);
        check_field("corner_c_y",  want.c.y,  corners.corner_c_y);
        check_field("source_of_a", want.src_a, corners.source_of_a);
        check_field("source_of_b", want.src_b, corners.source_of_b);
        check_field("source_of_c", want.src_c, corners.source_of_c);
      end
    end
  end

  // Sender: directed table first, then random triples, then drain and report.
  initial begin : point_source
    trio_t t;
    int    n;
    int    burst_left;
    burst_left    = 0;
    points.valid    <= 1'b0;
    points.first_x  <= '0;
    points.first_y  <= '0;
    points.second_x <= '0;
    points.second_y <= '0;
    points.third_x  <= '0;
    points.third_y  <= '0;
    do @(posedge clk); while (rst);

    foreach (directed_rows[i]) begin
      offer_trio(directed_rows[i].pts, idle_len());
      if (directed_rows[i].typed)
        expected_corners.push_back(directed_rows[i].want);
      else
        expected_corners.push_back(order_corners(directed_rows[i].pts));
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Twice per run: receiver holds off while we keep offering back to back.
      if (n == 0 || n == RANDOM_ITEMS / 2) begin
        hold_reqs++;
        burst_left    = 80;
      end else if (burst_left == 0 && $urandom_range(0, 99) == 0) begin
        burst_left = $urandom_range(20, 60);
      end
      t = random_trio();
      offer_trio(t, (burst_left > 0) ? 0 : idle_len());
      if (burst_left > 0) burst_left--;
      expected_corners.push_back(order_corners(t));
    end
    points.valid <= 1'b0;

    // Drain, then wait out the pipeline depth and a margin to catch stray items.
    while (expected_corners.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
